// ===== rtl/core/concatenated_trap_fitness_assert.svh =====
// assertion macros shared by the trap fitness modules
// each expects i_clk and i_rst_n in the enclosing module
`ifndef CONCATENATED_TRAP_FITNESS_ASSERT_SVH
`define CONCATENATED_TRAP_FITNESS_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CTF_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define CTF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ctf_pkg.sv =====
`default_nettype none
package ctf_pkg;

    localparam int WinW     = 16;
    localparam int KW       = 5;
    localparam int ScoreW   = 5;
    localparam int DeltaW   = 6;
    localparam int FitW     = 17;
    localparam int SumW     = 18;
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 5;

    localparam logic [KW-1:0] MaxTrapSize = 5'd16;
    localparam logic [KW-1:0] TrapSizeRst = 5'd5;
    localparam logic [KW-1:0] KSix        = 5'd6;
    localparam logic [KW-1:0] KTen        = 5'd10;

    localparam logic signed [FitW-1:0] FitMin = -17'sd65536;
    localparam logic signed [FitW-1:0] FitMax = 17'sd65535;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgTrapSize = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgBimodal  = 1'b1;

    // request commands
    localparam logic CmdAdd  = 1'b0;
    localparam logic CmdSwap = 1'b1;

    typedef struct packed {
        logic                     first;
        logic                     last;
        logic                     err;
        logic signed [FitW-1:0]   base;
        logic signed [DeltaW-1:0] delta;
    } t_delta_item;

    function automatic logic [ScoreW-1:0] bimodal10(input logic [ScoreW-1:0] u);
        logic [ScoreW-1:0] s;
        unique case (u)
            5'd0:    s = 5'd10;
            5'd1:    s = 5'd5;
            5'd2:    s = 5'd0;
            5'd3:    s = 5'd3;
            5'd4:    s = 5'd6;
            5'd5:    s = 5'd9;
            5'd6:    s = 5'd6;
            5'd7:    s = 5'd3;
            5'd8:    s = 5'd0;
            5'd9:    s = 5'd5;
            5'd10:   s = 5'd10;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [ScoreW-1:0] bimodal6(input logic [ScoreW-1:0] u);
        logic [ScoreW-1:0] s;
        unique case (u)
            5'd0:    s = 5'd6;
            5'd1:    s = 5'd0;
            5'd2:    s = 5'd2;
            5'd3:    s = 5'd5;
            5'd4:    s = 5'd2;
            5'd5:    s = 5'd0;
            5'd6:    s = 5'd6;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ctf_in_if.sv =====
`default_nettype none
interface ctf_in_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic                                first_item;
    logic signed [ctf_pkg::FitW-1:0]     base_value;
    logic        [ctf_pkg::WinW-1:0]     window_bits;
    logic        [ctf_pkg::WinW-1:0]     old_window_bits;
    logic                                last_item;

    modport source (
        output valid, command, first_item, base_value, window_bits, old_window_bits,
               last_item,
        input  ready
    );
    modport sink (
        input  valid, command, first_item, base_value, window_bits, old_window_bits,
               last_item,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/core/ctf_out_if.sv =====
`default_nettype none
interface ctf_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [ctf_pkg::FitW-1:0] fitness;
    logic                            size_error;

    modport source (
        output valid, fitness, size_error,
        input  ready
    );
    modport sink (
        input  valid, fitness, size_error,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/core/concatenated_trap_fitness.sv =====
`default_nettype none
`include "concatenated_trap_fitness_assert.svh"
// Concatenated deceptive trap fitness. One window request is taken every clock
// cycle unless output back-pressure stalls it; a request flows through an input
// register, a scoring stage (mask, popcount and trap or bimodal table for the
// new and old window) and the accumulate stage, whose output register holds the
// result of the request marked last. The running sum feeds back through one
// saturating add, which sets the one-request-per-cycle rate. A pending result
// in the output register only holds up a later request that is itself marked
// last. Trap size and bimodal mode must be written only while the block is
// idle, unenforced by the block; reset alone clears the sticky size error.
module concatenated_trap_fitness (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ctf_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [ctf_pkg::CfgDataW-1:0]  i_cfg_wdata,
    ctf_in_if.sink                             i_in,
    ctf_out_if.source                          o_out
);
    import ctf_pkg::*;

    logic [KW-1:0]          r_trap_size;
    logic                   r_bimodal;
    logic [KW-1:0]          k_eff;

    // input stage
    logic                   r_v1;
    logic                   r_cmd;
    logic                   r_first;
    logic signed [FitW-1:0] r_base;
    logic [WinW-1:0]        r_win;
    logic [WinW-1:0]        r_old;
    logic                   r_last;

    // score stage
    logic                   r_v2;
    t_delta_item            r_item, n_item;

    logic [ScoreW-1:0]      sc_new, sc_old;
    logic                   err_new, err_old;
    logic                   acc_ready;
    logic                   s2_free, s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trap_size <= TrapSizeRst;
            r_bimodal   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgTrapSize: r_trap_size <= i_cfg_wdata;
                CfgBimodal:  r_bimodal   <= i_cfg_wdata[0];
                default:     ;
            endcase
        end
    end

    assign k_eff = (r_trap_size > MaxTrapSize) ? MaxTrapSize : r_trap_size;

    assign s2_free    = !r_v2 || acc_ready;
    assign s1_free    = !r_v1 || s2_free;
    assign i_in.ready = s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s1_free) begin
                r_v1 <= i_in.valid;
            end
            if (s2_free) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_in.valid) begin
            r_cmd   <= i_in.command;
            r_first <= i_in.first_item;
            r_base  <= i_in.base_value;
            r_win   <= i_in.window_bits;
            r_old   <= i_in.old_window_bits;
            r_last  <= i_in.last_item;
        end
        if (s2_free && r_v1) begin
            r_item <= n_item;
        end
    end

    ctf_score u_score_new (
        .i_bits    (r_win),
        .i_k       (k_eff),
        .i_bimodal (r_bimodal),
        .o_score   (sc_new),
        .o_err     (err_new)
    );

    ctf_score u_score_old (
        .i_bits    (r_old),
        .i_k       (k_eff),
        .i_bimodal (r_bimodal),
        .o_score   (sc_old),
        .o_err     (err_old)
    );

    always_comb begin
        n_item.first = r_first;
        n_item.last  = r_last;
        n_item.base  = r_base;
        if (r_cmd == CmdSwap) begin
            n_item.delta = $signed({1'b0, sc_new}) - $signed({1'b0, sc_old});
            n_item.err   = err_new | err_old;
        end else begin
            n_item.delta = $signed({1'b0, sc_new});
            n_item.err   = err_new;
        end
    end

    ctf_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_item  (r_item),
        .o_ready (acc_ready),
        .o_out   (o_out)
    );

    `CTF_ASSERT_NEXT(a_accept_loads, i_in.valid && i_in.ready, r_v1, "accepted request lost")
    `CTF_ASSERT_NEXT(a_stage2_held, r_v2 && !acc_ready, r_v2, "stalled score stage dropped")
    `CTF_ASSERT_SAME(a_ready_chain, r_v1 && !s2_free, !i_in.ready, "input taken over full stage")

endmodule
`default_nettype wire

// ===== rtl/core/ctf_score.sv =====
`default_nettype none
module ctf_score (
    input  wire logic [ctf_pkg::WinW-1:0]   i_bits,
    input  wire logic [ctf_pkg::KW-1:0]     i_k,
    input  wire logic                       i_bimodal,
    output logic      [ctf_pkg::ScoreW-1:0] o_score,
    output logic                            o_err
);
    import ctf_pkg::*;

    logic [WinW-1:0]   masked;
    logic [2:0]        nib_cnt [4];
    logic [ScoreW-1:0] ones;

    // keep only the low k bits of the window
    always_comb begin
        for (int i = 0; i < WinW; i++) begin
            masked[i] = i_bits[i] & (KW'(i) < i_k);
        end
    end

    // count per nibble, then add the four nibble counts
    always_comb begin
        for (int n = 0; n < 4; n++) begin
            nib_cnt[n] = 3'd0;
            for (int b = 0; b < 4; b++) begin
                nib_cnt[n] = nib_cnt[n] + {2'd0, masked[4*n+b]};
            end
        end
        ones = ScoreW'(nib_cnt[0]) + ScoreW'(nib_cnt[1])
             + ScoreW'(nib_cnt[2]) + ScoreW'(nib_cnt[3]);
    end

    always_comb begin
        o_score = '0;
        o_err   = 1'b0;
        if (i_bimodal) begin
            if (i_k == KTen) begin
                o_score = bimodal10(ones);
            end else if (i_k == KSix) begin
                o_score = bimodal6(ones);
            end else begin
                o_err = 1'b1;
            end
        end else if (ones == i_k) begin
            o_score = i_k;
        end else begin
            o_score = i_k - 5'd1 - ones;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/ctf_accum.sv =====
`default_nettype none
`include "concatenated_trap_fitness_assert.svh"
module ctf_accum (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire ctf_pkg::t_delta_item i_item,
    output logic                      o_ready,
    ctf_out_if.source                 o_out
);
    import ctf_pkg::*;

    logic signed [FitW-1:0] r_sum, n_sum;
    logic                   r_err;
    logic                   r_ov;
    logic signed [FitW-1:0] r_fit;
    logic                   r_serr;
    logic                   retire;
    logic signed [SumW-1:0] start, total;

    // an item without a result never waits on the output register
    assign o_ready = !i_item.last || !r_ov || o_out.ready;
    assign retire  = i_valid && o_ready;

    always_comb begin
        start = i_item.first ? {i_item.base[FitW-1], i_item.base}
                             : {r_sum[FitW-1], r_sum};
        total = start + {{(SumW-DeltaW){i_item.delta[DeltaW-1]}}, i_item.delta};
        if (total < $signed({FitMin[FitW-1], FitMin})) begin
            n_sum = FitMin;
        end else if (total > $signed({FitMax[FitW-1], FitMax})) begin
            n_sum = FitMax;
        end else begin
            n_sum = total[FitW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_err <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (retire) begin
                r_sum <= n_sum;
                r_err <= r_err | i_item.err;
            end
            if (retire && i_item.last) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (retire && i_item.last) begin
            r_fit  <= n_sum;
            r_serr <= r_err | i_item.err;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.fitness    = r_fit;
    assign o_out.size_error = r_serr;

    `CTF_ASSERT_NEXT(a_err_sticky, r_err, r_err, "sticky size error cleared")
    `CTF_ASSERT_NEXT(a_first_load, retire && i_item.first && i_item.delta == '0, r_sum == $past(i_item.base), "first request did not load base")
    `CTF_ASSERT_NEXT(a_result_held, r_ov && !o_out.ready, r_ov && $stable(r_fit), "pending result changed")

endmodule
`default_nettype wire

// ===== test/tb_concatenated_trap_fitness.sv =====
`timescale 1ns / 1ps
module tb_concatenated_trap_fitness;
    import ctf_pkg::*;

    localparam int MaxK       = 16;
    localparam int SettleCyc  = 8;
    localparam int StallLimit = 1000;

    typedef struct {
        logic                   command;
        logic                   first_item;
        logic signed [FitW-1:0] base_value;
        logic [WinW-1:0]        window_bits;
        logic [WinW-1:0]        old_window_bits;
        logic                   last_item;
    } t_window_req;

    typedef struct {
        logic signed [FitW-1:0] fitness;
        logic                   size_error;
    } t_fitness_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_wdata;

    ctf_in_if  req_ch ();
    ctf_out_if res_ch ();

    concatenated_trap_fitness DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (req_ch),
        .o_out       (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // scoring model state
    int unsigned     trap_k      = 5;
    bit              bimodal_on  = 1'b0;
    int              running_fit = 0;
    bit              size_err    = 1'b0;
    t_fitness_result fitness_expected[$];
    t_fitness_result fit_want;
    int              errors      = 0;
    bit              idle_on     = 1'b1;
    int              stall_left  = 0;

    const int bimodal10_score[0:10] = '{10, 5, 0, 3, 6, 9, 6, 3, 0, 5, 10};
    const int bimodal6_score[0:6]   = '{6, 0, 2, 5, 2, 0, 6};

    function automatic int eff_k();
        return (trap_k > MaxK) ? MaxK : trap_k;
    endfunction

    function automatic int trap_score(input logic [WinW-1:0] bits, output bit bad);
        int k;
        int ones;
        k    = eff_k();
        ones = 0;
        bad  = 1'b0;
        for (int b = 0; b < k; b++) ones += bits[b];
        if (bimodal_on) begin
            if (k == 10) return bimodal10_score[ones];
            if (k == 6) return bimodal6_score[ones];
            bad = 1'b1;
            return 0;
        end
        return (ones == k) ? k : k - 1 - ones;
    endfunction

    function automatic void accumulate_window(input t_window_req r);
        bit              bad_new;
        bit              bad_old;
        int              delta;
        t_fitness_result res;
        bad_old = 1'b0;
        if (r.first_item) running_fit = r.base_value;
        delta = trap_score(r.window_bits, bad_new);
        if (r.command == CmdSwap) delta -= trap_score(r.old_window_bits, bad_old);
        running_fit += delta;
        if (running_fit < -65536) running_fit = -65536;
        if (running_fit > 65535) running_fit = 65535;
        if (bad_new || bad_old) size_err = 1'b1;
        if (r.last_item) begin
            res              = '{FitW'(running_fit), size_err};
            fitness_expected = {fitness_expected, res};
        end
    endfunction

    function automatic t_window_req make_req(input logic cmd, input logic first,
                                             input logic signed [FitW-1:0] base,
                                             input logic [WinW-1:0] win,
                                             input logic [WinW-1:0] old_win,
                                             input logic last);
        t_window_req r;
        r.command         = cmd;
        r.first_item      = first;
        r.base_value      = base;
        r.window_bits     = win;
        r.old_window_bits = old_win;
        r.last_item       = last;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [FitW-1:0] pick_base();
        case ($urandom_range(0, 3))
            0:       return FitW'(65535 - $urandom_range(0, 40));
            1:       return FitW'(-65536 + $urandom_range(0, 40));
            default: return FitW'($urandom);
        endcase
    endfunction

    function automatic logic [WinW-1:0] pick_window();
        logic [31:0] mask;
        mask = (32'h1 << eff_k()) - 32'h1;
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            2:       return WinW'(mask | ($urandom & ~mask));
            3:       return WinW'($urandom & ~mask);
            default: return WinW'($urandom);
        endcase
    endfunction

    // result side: random back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (idle_on && $urandom_range(0, 99) < 20) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(0, 2);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (fitness_expected.size() == 0) begin
                $error("unexpected result: fitness %0d size_error %0b",
                       res_ch.fitness, res_ch.size_error);
                errors++;
            end else begin
                fit_want = fitness_expected.pop_front();
                if (res_ch.fitness !== fit_want.fitness) begin
                    $error("fitness: expected %0d, got %0d", fit_want.fitness, res_ch.fitness);
                    errors++;
                end
                if (res_ch.size_error !== fit_want.size_error) begin
                    $error("size_error: expected %0b, got %0b",
                           fit_want.size_error, res_ch.size_error);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < StallLimit) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_window(input t_window_req r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.command         <= r.command;
        req_ch.first_item      <= r.first_item;
        req_ch.base_value      <= r.base_value;
        req_ch.window_bits     <= r.window_bits;
        req_ch.old_window_bits <= r.old_window_bits;
        req_ch.last_item       <= r.last_item;
        do @(posedge i_clk); while (!req_ch.ready);
        accumulate_window(r);
    endtask

    // requests without a result may still be in flight once the queue drains
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (fitness_expected.size() != 0) @(posedge i_clk);
        repeat (SettleCyc) @(posedge i_clk);
    endtask

    task automatic set_config(input int unsigned k, input bit bimodal);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CfgTrapSize;
        i_cfg_wdata <= CfgDataW'(k);
        @(posedge i_clk);
        i_cfg_index <= CfgBimodal;
        i_cfg_wdata <= CfgDataW'(bimodal);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        trap_k     = k & 32'h1F;
        bimodal_on = bimodal;
    endtask

    // well-formed evaluations with random content, plus stray first and last flags
    task automatic run_evaluations(input int n_items);
        int sent;
        int len;
        bit opens;
        logic first;
        logic last;
        sent = 0;
        while (sent < n_items) begin
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            opens = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 9) == 0) idle_on = ~idle_on;
            for (int i = 0; i < len; i++) begin
                first = (i == 0 && opens) || ($urandom_range(0, 49) == 0);
                last  = (i == len - 1) || ($urandom_range(0, 49) == 0);
                send_window(make_req(logic'($urandom_range(0, 1)), first, pick_base(),
                                     pick_window(), pick_window(), last));
            end
            sent += len;
        end
    endtask

    task automatic test_reset_accumulate();
        idle_on = 1'b0;
        // no first request: carries on from the reset sum
        send_window(make_req(CmdAdd, 1'b0, '0, 16'h001F, '0, 1'b1));
        send_window(make_req(CmdAdd, 1'b0, '0, 16'h0000, '0, 1'b0));
        send_window(make_req(CmdAdd, 1'b0, '0, 16'hFFFF, '0, 1'b1));
    endtask

    task automatic test_saturation();
        set_config(16, 1'b0);
        idle_on = 1'b1;
        send_window(make_req(CmdAdd, 1'b1, FitMax, 16'hFFFF, '0, 1'b1));
        send_window(make_req(CmdSwap, 1'b1, FitMin, 16'h0000, 16'hFFFF, 1'b1));
        send_window(make_req(CmdAdd, 1'b1, FitMin, 16'hFFFF, 16'hFFFF, 1'b1));
        send_window(make_req(CmdSwap, 1'b1, 17'sd0, 16'h7FFF, 16'h0000, 1'b1));
    endtask

    task automatic test_odd_sizes();
        set_config(0, 1'b0);
        send_window(make_req(CmdAdd, 1'b1, 17'sd0, 16'hFFFF, '0, 1'b1));
        set_config(1, 1'b0);
        send_window(make_req(CmdAdd, 1'b1, 17'sd100, 16'h0001, '0, 1'b0));
        send_window(make_req(CmdSwap, 1'b0, '0, 16'hFFFE, 16'h0001, 1'b1));
        // sizes above the maximum act as sixteen
        set_config(31, 1'b0);
        send_window(make_req(CmdAdd, 1'b1, 17'sd0, 16'hFFFF, '0, 1'b0));
        send_window(make_req(CmdSwap, 1'b0, '0, 16'h0000, 16'hFFFF, 1'b1));
        set_config(2, 1'b0);
        send_window(make_req(CmdAdd, 1'b1, 17'sd7, 16'hFFFC, '0, 1'b1));
    endtask

    task automatic test_bimodal();
        set_config(6, 1'b1);
        send_window(make_req(CmdAdd, 1'b1, 17'sd0, 16'h0000, '0, 1'b0));
        send_window(make_req(CmdAdd, 1'b0, '0, 16'hFF07, '0, 1'b0));
        send_window(make_req(CmdSwap, 1'b0, '0, 16'h003F, 16'hFFC1, 1'b1));
        set_config(10, 1'b1);
        send_window(make_req(CmdAdd, 1'b1, -17'sd3, 16'h03FF, '0, 1'b0));
        send_window(make_req(CmdSwap, 1'b0, '0, 16'h001F, 16'h0003, 1'b1));
    endtask

    task automatic test_random_phases();
        int unsigned phase_k[14]   = '{5, 2, 16, 3, 6, 10, 0, 1, 31, 17, 12, 6, 10, 8};
        bit          phase_bim[14] = '{0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 1};
        for (int p = 0; p < 14; p++) begin
            // bimodal phases keep to supported sizes so the sticky flag stays clear
            if (phase_bim[p] && phase_k[p] != 6 && phase_k[p] != 10) phase_k[p] = 10;
            set_config(phase_k[p], phase_bim[p]);
            idle_on = ($urandom_range(0, 9) < 7);
            run_evaluations(130);
        end
    endtask

    // the error flag is sticky until reset, so this runs last
    task automatic test_size_error();
        set_config(5, 1'b1);
        idle_on = 1'b1;
        send_window(make_req(CmdAdd, 1'b1, 17'sd20, 16'h001F, '0, 1'b1));
        set_config(6, 1'b1);
        send_window(make_req(CmdAdd, 1'b1, 17'sd0, 16'h003F, '0, 1'b1));
        run_evaluations(50);
        set_config(16, 1'b1);
        run_evaluations(60);
        set_config(0, 1'b1);
        run_evaluations(60);
        set_config(4, 1'b0);
        run_evaluations(60);
    endtask

    initial begin
        i_rst_n                <= 1'b0;
        i_cfg_we               <= 1'b0;
        i_cfg_index            <= CfgTrapSize;
        i_cfg_wdata            <= '0;
        req_ch.valid           <= 1'b0;
        req_ch.command         <= CmdAdd;
        req_ch.first_item      <= 1'b0;
        req_ch.base_value      <= '0;
        req_ch.window_bits     <= '0;
        req_ch.old_window_bits <= '0;
        req_ch.last_item       <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_accumulate();
        test_saturation();
        test_odd_sizes();
        test_bimodal();
        test_random_phases();
        test_size_error();

        wait_idle();
        repeat (SettleCyc) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ctf_pkg.sv
rtl/core/ctf_in_if.sv
rtl/core/ctf_out_if.sv
rtl/core/ctf_score.sv
rtl/core/ctf_accum.sv
rtl/core/concatenated_trap_fitness.sv
test/tb_concatenated_trap_fitness.sv
